@@ hw/rtl/pip_pkg.sv @@
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 12;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int COUNT_BITS   = 7;
    localparam int INDEX_BITS   = 6;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS     = PROD_BITS + 1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    typedef struct packed {
        logic clear;
        logic load_prev;
        logic eval;
    } edge_ctl_t;

endpackage

@@ hw/rtl/pip_vertex_ram.sv @@
module pip_vertex_ram (
    input  logic             aclk,
    input  logic             wr_en,
    input  pip_pkg::addr_t   wr_addr,
    input  pip_pkg::vertex_t wr_data,
    input  logic             rd_en,
    input  pip_pkg::addr_t   rd_addr,
    output pip_pkg::vertex_t rd_data
);
    import pip_pkg::*;

    vertex_t mem [MAX_VERTICES];
    vertex_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pip_edge_unit.sv @@
module pip_edge_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  pip_pkg::edge_ctl_t ctl,
    input  pip_pkg::vertex_t   vertex,
    input  pip_pkg::coord_t    query_x,
    input  pip_pkg::coord_t    query_y,
    output logic               busy,
    output logic               inside_flag
);
    import pip_pkg::*;

    vertex_t prev_reg;

    logic                        a_vld_reg;
    logic                        a_qual_reg;
    logic signed [DIFF_BITS-1:0] da_reg, dy_reg, dq_reg, dx_reg;

    logic                        b_vld_reg;
    logic                        b_qual_reg;
    logic signed [PROD_BITS-1:0] p1_reg, p2_reg;

    logic inside_reg;
    logic inside_next;

    logic    cur_above, prev_above, qual;
    vertex_t va, vb;
    logic signed [SUM_BITS-1:0] sum;

    // The endpoint above the query line is a, the other one is b.
    always_comb begin
        cur_above  = (vertex.y < query_y) && (prev_reg.y >= query_y);
        prev_above = (prev_reg.y < query_y) && (vertex.y >= query_y);
        qual       = (cur_above || prev_above)
                     && ((vertex.x >= query_x) || (prev_reg.x >= query_x));
        va         = cur_above ? vertex : prev_reg;
        vb         = cur_above ? prev_reg : vertex;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_prev || ctl.eval) begin
            prev_reg <= vertex;
        end
        if (ctl.eval) begin
            a_qual_reg <= qual;
            da_reg     <= $signed({1'b0, va.x}) - $signed({1'b0, query_x});
            dy_reg     <= $signed({1'b0, vb.y}) - $signed({1'b0, va.y});
            dq_reg     <= $signed({1'b0, query_y}) - $signed({1'b0, va.y});
            dx_reg     <= $signed({1'b0, vb.x}) - $signed({1'b0, va.x});
        end
        if (a_vld_reg) begin
            b_qual_reg <= a_qual_reg;
            p1_reg     <= da_reg * dy_reg;
            p2_reg     <= dq_reg * dx_reg;
        end
    end

    assign sum = {p1_reg[PROD_BITS-1], p1_reg} + {p2_reg[PROD_BITS-1], p2_reg};

    always_comb begin
        inside_next = inside_reg;
        if (ctl.clear) begin
            inside_next = 1'b0;
        end else if (b_vld_reg && b_qual_reg && !sum[SUM_BITS-1]) begin
            inside_next = !inside_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            a_vld_reg  <= ctl.eval;
            b_vld_reg  <= a_vld_reg;
            inside_reg <= inside_next;
        end
    end

    assign busy        = a_vld_reg || b_vld_reg;
    assign inside_flag = inside_reg;

endmodule

@@ hw/rtl/point_in_polygon_test_top.sv @@
// Point-in-polygon test by even-odd ray casting.
// The input channel (s_valid/s_ready) carries two kinds of item. A vertex write
// (s_kind 0) stores s_coord_x and s_coord_y in slot s_vertex_index and
// produces no result. A query (s_kind 1) tests the point
// s_coord_x, s_coord_y against the first vertex_count vertices and produces
// one item on the result channel (m_valid/m_ready) with m_inside_res.
// The vertex count is written through cfg_wr_en and cfg_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// Values above the table depth act as the full table. A query with n vertices
// reads one vertex per cycle from the table and feeds one shared edge unit
// (difference stage, multiply stage, accumulate); s_ready is low until the
// result is registered. A count of zero skips the table walk.
// The result sits in an output register. The block accepts new items while it
// waits; a following query holds its result until the old one is taken.
// Reset clears the count, the sequencer and the output valid. The vertex
// table is not cleared: every slot a query uses must be written first.
module point_in_polygon_test_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pip_pkg::COUNT_BITS-1:0]  cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [pip_pkg::INDEX_BITS-1:0]  s_vertex_index,
    input  logic [pip_pkg::COORD_BITS-1:0]  s_coord_x,
    input  logic [pip_pkg::COORD_BITS-1:0]  s_coord_y,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_inside_res
);
    import pip_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PREV  = 5'b00010,
        S_WALK  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    count_t vertex_count_reg;
    count_t n_reg, n_next;
    addr_t  idx_reg, idx_next;
    coord_t qx_reg, qy_reg;
    logic   rd_vld_reg, rd_prev_reg;
    logic   m_valid_reg, m_valid_next;
    logic   m_inside_reg;

    logic      in_fire, wr_en, rd_en, rd_prev, load_out, busy, inside_flag;
    addr_t     rd_addr;
    vertex_t   rd_data;
    edge_ctl_t ctl;
    count_t    n_sat, n_last;

    assign in_fire = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign wr_en   = in_fire && (s_kind == KIND_WRITE);
    assign n_sat   = (vertex_count_reg > COUNT_BITS'(MAX_VERTICES))
                     ? COUNT_BITS'(MAX_VERTICES) : vertex_count_reg;
    assign n_last  = n_reg - 1'b1;
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_prev    = 1'b0;
        rd_addr    = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_kind == KIND_QUERY)) begin
                    n_next     = n_sat;
                    idx_next   = '0;
                    state_next = (n_sat == '0) ? S_DONE : S_PREV;
                end
            end
            S_PREV: begin
                rd_en      = 1'b1;
                rd_prev    = 1'b1;
                rd_addr    = n_last[ADDR_BITS-1:0];
                state_next = S_WALK;
            end
            S_WALK: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + 1'b1;
                if ({1'b0, idx_reg} == n_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!rd_vld_reg && !busy) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign ctl.clear     = in_fire && (s_kind == KIND_QUERY);
    assign ctl.load_prev = rd_vld_reg && rd_prev_reg;
    assign ctl.eval      = rd_vld_reg && !rd_prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            vertex_count_reg <= '0;
            rd_vld_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                vertex_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        rd_prev_reg <= rd_prev;
        if (ctl.clear) begin
            qx_reg <= s_coord_x;
            qy_reg <= s_coord_y;
        end
        if (load_out) begin
            m_inside_reg <= inside_flag;
        end
    end

    pip_vertex_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_vertex_index[ADDR_BITS-1:0]),
        .wr_data ({s_coord_x, s_coord_y}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_edge_unit u_edge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .vertex      (rd_data),
        .query_x     (qx_reg),
        .query_y     (qy_reg),
        .busy        (busy),
        .inside_flag (inside_flag)
    );

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    a_query_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_kind == KIND_QUERY)) |=> (state_reg != S_IDLE))
        else $error("query accepted but sequencer stayed idle");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> ({1'b0, idx_reg} < n_reg))
        else $error("walk index beyond vertex count");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!rd_vld_reg && !busy))
        else $error("edge pipeline busy while idle");

endmodule
